[src/ott_pkg.sv]
package ott_pkg;

    localparam int SEQ_BITS    = 32;
    localparam int SLOT_BITS   = 4;
    localparam int MAX_RESULTS = 16;
    localparam int RES_AW      = $clog2(MAX_RESULTS);
    localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_NOP    = 2'd3;

    // response kinds
    localparam logic [1:0] RESP_ADD    = 2'd0;
    localparam logic [1:0] RESP_CANCEL = 2'd1;
    localparam logic [1:0] RESP_FIRED  = 2'd2;
    localparam logic [1:0] RESP_IDLE   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // what the current slot sweep is looking for
    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_CANCEL = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_FIN    = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]           kind;
        logic [1:0]           status;
        logic [SLOT_BITS-1:0] slot;
        logic [SEQ_BITS-1:0]  seq;
        logic                 early;
    } t_result;

    typedef struct packed {
        logic take;       // capture this slot as the pick
        logic early_clr;  // new timer is not the earliest
    } t_eval;

endpackage

[src/ordered_timer_table_unit.sv]
// channel | valid       | stall        | payload
// request | i_in_valid  | o_in_stall   | i_req_type, i_now_time, i_expire_time,
//         |             |              | i_repeat_interval, i_cancel_slot, i_cancel_seq
// result  | o_out_valid | i_out_stall  | o_resp_kind, o_status, o_slot_out, o_seq_out,
//         |             |              | o_earliest_changed, o_next_valid,
//         |             |              | o_next_deadline, o_last
//
// one transaction at a time; every slot sweep reads the slot memory once per slot
// add and cancel: one sweep, an update, one deadline sweep and its update, then the result
// tick: one sweep per fired timer (up to 16), a sweep that finds none unless 16 fired,
// then a deadline sweep; results follow one at a time, each read from the result buffer
// (S_RD) and then loaded into the output register (S_LD)
// reset is synchronous and active low; it clears valid bits and the sequence counter
// a stalled result holds in the output register; the next request is taken once the
// last result of a transaction is loaded there
module ordered_timer_table_unit #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_req_type,
    input  logic [TIME_BITS-1:0]          i_now_time,
    input  logic [TIME_BITS-1:0]          i_expire_time,
    input  logic [TIME_BITS-1:0]          i_repeat_interval,
    input  logic [ott_pkg::SLOT_BITS-1:0] i_cancel_slot,
    input  logic [ott_pkg::SEQ_BITS-1:0]  i_cancel_seq,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_resp_kind,
    output logic [1:0]                    o_status,
    output logic [ott_pkg::SLOT_BITS-1:0] o_slot_out,
    output logic [ott_pkg::SEQ_BITS-1:0]  o_seq_out,
    output logic                          o_earliest_changed,
    output logic                          o_next_valid,
    output logic [TIME_BITS-1:0]          o_next_deadline,
    output logic                          o_last
);

    localparam int SW  = $clog2(NUM_TIMERS);
    localparam int QB  = ott_pkg::SEQ_BITS;
    localparam int EW  = 2 * TIME_BITS + QB;   // {expiry, interval, seq}
    localparam int RAW = ott_pkg::RES_AW;
    localparam int RCW = ott_pkg::RES_CW;
    localparam int RW  = $bits(ott_pkg::t_result);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_UPD  = 5'b00100,
        S_RD   = 5'b01000,
        S_LD   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // control
    logic [NUM_TIMERS-1:0] r_valid;
    logic [NUM_TIMERS-1:0] r_done;     // fired already in this tick
    logic [QB-1:0]         r_seqc;
    ott_pkg::t_mode        r_mode;
    logic [SW:0]           r_idx;      // next slot to read
    logic                  r_rvld;     // read data returns this cycle
    logic [SW-1:0]         r_ridx;     // slot of returning data
    logic                  r_found;
    logic                  r_early;
    logic [RCW-1:0]        r_n;        // results buffered
    logic [RAW-1:0]        r_k;        // result being emitted
    logic                  r_ovalid, n_ovalid;
    logic                  r_dl_valid;

    // payload
    logic [TIME_BITS-1:0]          r_now, r_exp, r_iv, r_best, r_pint, r_dl;
    logic [ott_pkg::SLOT_BITS-1:0] r_cslot;
    logic [QB-1:0]                 r_cseq, r_pseq;
    logic [SW-1:0]                 r_pick;
    ott_pkg::t_result              r_ores;
    logic                          r_onv, r_olast;
    logic [TIME_BITS-1:0]          r_odl;

    // slot memory
    logic           slot_we;
    logic [SW-1:0]  slot_waddr;
    logic [EW-1:0]  slot_wdata;
    logic [EW-1:0]  slot_rdata;
    logic [TIME_BITS-1:0] rd_exp, rd_iv;
    logic [QB-1:0]        rd_seq;

    // result buffer
    logic             res_we;
    logic [RAW-1:0]   res_waddr;
    ott_pkg::t_result res_wdata;
    logic [RW-1:0]    res_rdata;

    ott_pkg::t_eval       ev;
    logic                 in_acc, out_acc, scan_done, load_out, is_last;
    logic [TIME_BITS:0]   rearm_sum;
    logic [TIME_BITS-1:0] rearm;
    logic [QB-1:0]        seq_next;
    logic [RCW-1:0]       n_plus;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_acc   = r_ovalid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign {rd_exp, rd_iv, rd_seq} = slot_rdata;
    assign scan_done = (r_idx == (SW+1)'(NUM_TIMERS)) && !r_rvld;
    assign rearm_sum = {1'b0, r_now} + {1'b0, r_pint};
    // saturate the re-arm time at the top of the time range
    assign rearm     = rearm_sum[TIME_BITS] ? '1 : rearm_sum[TIME_BITS-1:0];
    assign seq_next  = r_seqc + 1'b1;
    assign n_plus    = r_n + 1'b1;
    assign load_out  = (r_state == S_LD) && (!r_ovalid || !i_out_stall);
    assign is_last   = ((RCW'(r_k) + 1'b1) == r_n);

    ott_ram #(.WIDTH(EW), .DEPTH(NUM_TIMERS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (r_idx[SW-1:0]),
        .o_rdata (slot_rdata)
    );

    ott_ram #(.WIDTH(RW), .DEPTH(ott_pkg::MAX_RESULTS)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_raddr (r_k),
        .o_rdata (res_rdata)
    );

    ott_eval #(.TIME_BITS(TIME_BITS), .SLOT_W(SW)) u_eval (
        .i_mode    (r_mode),
        .i_idx     (r_ridx),
        .i_valid   (r_valid[r_ridx]),
        .i_done    (r_done[r_ridx]),
        .i_exp     (rd_exp),
        .i_seq     (rd_seq),
        .i_now     (r_now),
        .i_add_exp (r_exp),
        .i_cslot   (r_cslot),
        .i_cseq    (r_cseq),
        .i_found   (r_found),
        .i_best    (r_best),
        .o_ev      (ev)
    );

    // memory writes and result buffer writes happen only in the update cycle
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_pick;
        slot_wdata = {rearm, r_pint, r_pseq};
        res_we     = 1'b0;
        res_waddr  = r_n[RAW-1:0];
        res_wdata  = '0;
        if (r_state == S_UPD) begin
            case (r_mode)
                ott_pkg::MODE_ADD: begin
                    res_we    = 1'b1;
                    res_waddr = '0;
                    if (r_found) begin
                        slot_we    = 1'b1;
                        slot_wdata = {r_exp, r_iv, seq_next};
                        res_wdata  = '{ott_pkg::RESP_ADD, ott_pkg::ST_OK,
                                       ott_pkg::SLOT_BITS'(r_pick), seq_next, r_early};
                    end else begin
                        res_wdata  = '{ott_pkg::RESP_ADD, ott_pkg::ST_FULL,
                                       '0, '0, 1'b0};
                    end
                end
                ott_pkg::MODE_CANCEL: begin
                    res_we    = 1'b1;
                    res_waddr = '0;
                    res_wdata = '{ott_pkg::RESP_CANCEL,
                                  r_found ? ott_pkg::ST_OK : ott_pkg::ST_NOT_FOUND,
                                  r_cslot, r_cseq, 1'b0};
                end
                ott_pkg::MODE_TICK: begin
                    if (r_found) begin
                        slot_we   = (r_pint != '0);
                        res_we    = 1'b1;
                        res_wdata = '{ott_pkg::RESP_FIRED, ott_pkg::ST_OK,
                                      ott_pkg::SLOT_BITS'(r_pick), r_pseq, 1'b0};
                    end else if (r_n == '0) begin
                        res_we    = 1'b1;
                        res_wdata = '{ott_pkg::RESP_IDLE, ott_pkg::ST_OK, '0, '0, 1'b0};
                    end
                end
                default: begin
                    slot_we = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_req_type != ott_pkg::REQ_NOP)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = (r_mode == ott_pkg::MODE_FIN) ? S_RD : S_SCAN;
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (load_out) begin
                    n_state = is_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (load_out) begin
            n_ovalid = 1'b1;
        end else if (out_acc) begin
            n_ovalid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_done     <= '0;
            r_seqc     <= '0;
            r_mode     <= ott_pkg::MODE_FIN;
            r_idx      <= '0;
            r_rvld     <= 1'b0;
            r_ridx     <= '0;
            r_found    <= 1'b0;
            r_early    <= 1'b1;
            r_n        <= '0;
            r_k        <= '0;
            r_ovalid   <= 1'b0;
            r_dl_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_done  <= '0;
                        r_n     <= '0;
                        r_idx   <= '0;
                        r_rvld  <= 1'b0;
                        r_found <= 1'b0;
                        r_early <= 1'b1;
                        case (i_req_type)
                            ott_pkg::REQ_ADD:    r_mode <= ott_pkg::MODE_ADD;
                            ott_pkg::REQ_CANCEL: r_mode <= ott_pkg::MODE_CANCEL;
                            ott_pkg::REQ_TICK:   r_mode <= ott_pkg::MODE_TICK;
                            default:             r_mode <= ott_pkg::MODE_FIN;
                        endcase
                    end
                end
                S_SCAN: begin
                    // issue one read per cycle, evaluate the slot read last cycle
                    if (r_idx != (SW+1)'(NUM_TIMERS)) begin
                        r_ridx <= r_idx[SW-1:0];
                        r_rvld <= 1'b1;
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_rvld <= 1'b0;
                    end
                    if (r_rvld) begin
                        if (ev.take) begin
                            r_found <= 1'b1;
                        end
                        if (ev.early_clr) begin
                            r_early <= 1'b0;
                        end
                    end
                end
                S_UPD: begin
                    r_idx   <= '0;
                    r_rvld  <= 1'b0;
                    r_found <= 1'b0;
                    r_early <= 1'b1;
                    r_k     <= '0;
                    case (r_mode)
                        ott_pkg::MODE_ADD: begin
                            if (r_found) begin
                                r_seqc          <= seq_next;
                                r_valid[r_pick] <= 1'b1;
                            end
                            r_n    <= RCW'(1);
                            r_mode <= ott_pkg::MODE_FIN;
                        end
                        ott_pkg::MODE_CANCEL: begin
                            if (r_found) begin
                                r_valid[r_pick] <= 1'b0;
                            end
                            r_n    <= RCW'(1);
                            r_mode <= ott_pkg::MODE_FIN;
                        end
                        ott_pkg::MODE_TICK: begin
                            if (r_found) begin
                                r_done[r_pick] <= 1'b1;
                                if (r_pint == '0) begin
                                    r_valid[r_pick] <= 1'b0;
                                end
                                r_n <= n_plus;
                                if (n_plus == RCW'(ott_pkg::MAX_RESULTS)) begin
                                    r_mode <= ott_pkg::MODE_FIN;
                                end
                            end else begin
                                if (r_n == '0) begin
                                    r_n <= RCW'(1);
                                end
                                r_mode <= ott_pkg::MODE_FIN;
                            end
                        end
                        default: begin
                            r_dl_valid <= r_found;
                        end
                    endcase
                end
                S_LD: begin
                    if (load_out && !is_last) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: begin
                    r_rvld <= 1'b0;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now   <= i_now_time;
            r_exp   <= i_expire_time;
            r_iv    <= i_repeat_interval;
            r_cslot <= i_cancel_slot;
            r_cseq  <= i_cancel_seq;
        end
        if ((r_state == S_SCAN) && r_rvld && ev.take) begin
            r_pick <= r_ridx;
            r_best <= rd_exp;
            r_pint <= rd_iv;
            r_pseq <= rd_seq;
        end
        if ((r_state == S_UPD) && (r_mode == ott_pkg::MODE_FIN)) begin
            r_dl <= r_found ? r_best : '0;
        end
        if (load_out) begin
            r_ores  <= ott_pkg::t_result'(res_rdata);
            r_onv   <= r_dl_valid;
            r_odl   <= r_dl;
            r_olast <= is_last;
        end
    end

    assign o_out_valid        = r_ovalid;
    assign o_resp_kind        = r_ores.kind;
    assign o_status           = r_ores.status;
    assign o_slot_out         = r_ores.slot;
    assign o_seq_out          = r_ores.seq;
    assign o_earliest_changed = r_ores.early;
    assign o_next_valid       = r_onv;
    assign o_next_deadline    = r_odl;
    assign o_last             = r_olast;

`ifndef NO_ASSERTIONS
    a_n_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= RCW'(ott_pkg::MAX_RESULTS))
        else $error("result count beyond buffer depth");

    a_rd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_LD) |-> (RCW'(r_k) < r_n))
        else $error("emitting past buffered results");

    a_add_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_mode == ott_pkg::MODE_ADD && r_found)
        |=> r_valid[$past(r_pick)])
        else $error("added slot not marked valid");

    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_UPD) |-> !load_out)
        else $error("result loaded during sweep");
`endif

endmodule

[src/ott_ram.sv]
module ott_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/ott_eval.sv]
module ott_eval #(
    parameter int TIME_BITS = 48,
    parameter int SLOT_W    = 4
) (
    input  ott_pkg::t_mode                 i_mode,
    input  logic [SLOT_W-1:0]              i_idx,
    input  logic                           i_valid,
    input  logic                           i_done,
    input  logic [TIME_BITS-1:0]           i_exp,
    input  logic [ott_pkg::SEQ_BITS-1:0]   i_seq,
    input  logic [TIME_BITS-1:0]           i_now,
    input  logic [TIME_BITS-1:0]           i_add_exp,
    input  logic [ott_pkg::SLOT_BITS-1:0]  i_cslot,
    input  logic [ott_pkg::SEQ_BITS-1:0]   i_cseq,
    input  logic                           i_found,
    input  logic [TIME_BITS-1:0]           i_best,
    output ott_pkg::t_eval                 o_ev
);

    localparam int CW = (SLOT_W > ott_pkg::SLOT_BITS) ? SLOT_W : ott_pkg::SLOT_BITS;

    logic better;
    logic slot_hit;

    assign better   = !i_found || (i_exp < i_best);
    assign slot_hit = (CW'(i_idx) == CW'(i_cslot));

    always_comb begin
        o_ev = '0;
        case (i_mode)
            ott_pkg::MODE_ADD: begin
                o_ev.take      = !i_valid && !i_found;
                o_ev.early_clr = i_valid && (i_exp <= i_add_exp);
            end
            ott_pkg::MODE_CANCEL: begin
                o_ev.take = i_valid && slot_hit && (i_seq == i_cseq);
            end
            ott_pkg::MODE_TICK: begin
                o_ev.take = i_valid && !i_done && (i_exp <= i_now) && better;
            end
            ott_pkg::MODE_FIN: begin
                o_ev.take = i_valid && better;
            end
            default: begin
                o_ev = '0;
            end
        endcase
    end

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = 16;
    localparam int TB = 48;
    localparam logic [TB-1:0] TMAX = {TB{1'b1}};
    localparam int LIMIT = 400000;

    // one request transaction as driven on the input port
    typedef struct {
        logic [1:0]    req;
        logic [TB-1:0] now;
        logic [TB-1:0] exp;
        logic [TB-1:0] iv;
        logic [3:0]    cslot;
        logic [31:0]   cseq;
    } t_req;

    // one expected result transaction
    typedef struct {
        logic [1:0]    kind;
        logic [1:0]    status;
        logic [3:0]    slot;
        logic [31:0]   seq;
        logic          early;
        logic          nvalid;
        logic [TB-1:0] ndead;
        logic          last;
    } t_resp;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    logic [1:0]    i_req_type;
    logic [TB-1:0] i_now_time;
    logic [TB-1:0] i_expire_time;
    logic [TB-1:0] i_repeat_interval;
    logic [3:0]    i_cancel_slot;
    logic [31:0]   i_cancel_seq;
    logic          o_out_valid;
    logic          i_out_stall;
    logic [1:0]    o_resp_kind;
    logic [1:0]    o_status;
    logic [3:0]    o_slot_out;
    logic [31:0]   o_seq_out;
    logic          o_earliest_changed;
    logic          o_next_valid;
    logic [TB-1:0] o_next_deadline;
    logic          o_last;

    ordered_timer_table_unit #(.NUM_TIMERS(NT), .TIME_BITS(TB)) dut (.*);

    // shadow copy of the timer table
    logic          tbl_valid [NT];
    logic [TB-1:0] tbl_expiry[NT];
    logic [TB-1:0] tbl_iv    [NT];
    logic [31:0]   tbl_seq   [NT];
    logic [31:0]   seq_count;

    t_req  pending_reqs[$];
    t_resp expected_resps[$];
    int    errors = 0;
    bit    stim_done = 0;
    int    cycle = 0;

    initial begin
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        seq_count = '0;
    end

    // apply one request to the shadow table and queue what the block should return
    task automatic predict_timer_step(input t_req r);
        t_resp         rs[$];
        t_resp         e;
        int            free_slot;
        int            pick;
        bit            earliest;
        bit            fired[NT];
        bit            any;
        logic [TB-1:0] best;
        if (r.req == ott_pkg::REQ_NOP) return;
        e = '{default: '0};
        if (r.req == ott_pkg::REQ_ADD) begin
            free_slot = -1;
            earliest = 1;
            for (int i = 0; i < NT; i++) begin
                if (!tbl_valid[i]) begin
                    if (free_slot < 0) free_slot = i;
                end else if (tbl_expiry[i] <= r.exp) begin
                    earliest = 0;
                end
            end
            e.kind = ott_pkg::RESP_ADD;
            if (free_slot < 0) begin
                e.status = ott_pkg::ST_FULL;
            end else begin
                seq_count++;
                tbl_valid[free_slot] = 1;
                tbl_expiry[free_slot] = r.exp;
                tbl_iv[free_slot] = r.iv;
                tbl_seq[free_slot] = seq_count;
                e.status = ott_pkg::ST_OK;
                e.slot = 4'(free_slot);
                e.seq = seq_count;
                e.early = earliest;
            end
            rs.push_back(e);
        end else if (r.req == ott_pkg::REQ_CANCEL) begin
            e.kind = ott_pkg::RESP_CANCEL;
            e.status = ott_pkg::ST_NOT_FOUND;
            e.slot = r.cslot;
            e.seq = r.cseq;
            if (tbl_valid[r.cslot] && tbl_seq[r.cslot] == r.cseq) begin
                tbl_valid[r.cslot] = 0;
                e.status = ott_pkg::ST_OK;
            end
            rs.push_back(e);
        end else begin
            foreach (fired[i]) fired[i] = 0;
            while (rs.size() < ott_pkg::MAX_RESULTS) begin
                pick = -1;
                for (int i = 0; i < NT; i++)
                    if (tbl_valid[i] && !fired[i] && tbl_expiry[i] <= r.now &&
                        (pick < 0 || tbl_expiry[i] < tbl_expiry[pick]))
                        pick = i;
                if (pick < 0) break;
                fired[pick] = 1;
                e.kind = ott_pkg::RESP_FIRED;
                e.status = ott_pkg::ST_OK;
                e.slot = 4'(pick);
                e.seq = tbl_seq[pick];
                rs.push_back(e);
                if (tbl_iv[pick] != 0)
                    tbl_expiry[pick] = (tbl_iv[pick] > TMAX - r.now) ? TMAX
                                                                     : r.now + tbl_iv[pick];
                else
                    tbl_valid[pick] = 0;
            end
            if (rs.size() == 0) begin
                e.kind = ott_pkg::RESP_IDLE;
                e.status = ott_pkg::ST_OK;
                rs.push_back(e);
            end
        end
        // every result carries the deadline left after the whole step
        any = 0;
        best = '0;
        for (int i = 0; i < NT; i++)
            if (tbl_valid[i] && (!any || tbl_expiry[i] < best)) begin
                best = tbl_expiry[i];
                any = 1;
            end
        foreach (rs[k]) begin
            rs[k].nvalid = any;
            rs[k].ndead = best;
            rs[k].last = (k == rs.size() - 1);
            expected_resps.push_back(rs[k]);
        end
    endtask

    // recent sequence numbers, so some cancels hit
    function automatic t_req mk_cancel(bit hit, logic [31:0] recent);
        t_req r;
        int   s;
        r = '{default: '0};
        r.req = ott_pkg::REQ_CANCEL;
        r.now = TB'({$urandom, $urandom});
        s = $urandom_range(0, NT - 1);
        r.cslot = 4'(s);
        r.cseq = (hit && recent != 0) ? recent - $urandom_range(0, 6) : $urandom;
        return r;
    endfunction

    function automatic t_req mk_add(logic [TB-1:0] base);
        t_req r;
        r.req = ott_pkg::REQ_ADD;
        r.now = TB'({$urandom, $urandom});
        r.cslot = 4'($urandom);
        r.cseq = $urandom;
        r.exp = base + TB'($urandom_range(0, 200));
        case ($urandom_range(0, 3))
            0: r.iv = '0;
            1: r.iv = TB'($urandom_range(1, 100));
            2: r.iv = TB'({$urandom, $urandom});
            default: r.iv = '0;
        endcase
        if ($urandom_range(0, 9) == 0) r.exp = TB'({$urandom, $urandom});
        return r;
    endfunction

    function automatic t_req mk_tick(logic [TB-1:0] now);
        t_req r;
        r = '{default: '0};
        r.req = ott_pkg::REQ_TICK;
        r.now = now;
        r.exp = TB'({$urandom, $urandom});
        r.iv = TB'({$urandom, $urandom});
        r.cseq = $urandom;
        r.cslot = 4'($urandom);
        return r;
    endfunction

    // clock and reset
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // stimulus
    initial begin
        t_req          r;
        logic [TB-1:0] now;
        logic [31:0]   adds;
        now = 1000;
        adds = '0;
        // fill past full, with extreme field values
        r = mk_add(0); r.exp = '0; r.iv = '0; pending_reqs.push_back(r);
        r = mk_add(0); r.exp = TMAX; r.iv = TMAX; pending_reqs.push_back(r);
        r = mk_add(0); r.exp = 5; r.iv = TMAX; pending_reqs.push_back(r);
        for (int i = 0; i < 14; i++) begin
            r = mk_add(50); r.exp = TB'(50 + (i % 3)); r.iv = TB'(i % 2);
            pending_reqs.push_back(r);
        end
        adds = 32'd16;
        r = mk_tick(TMAX); pending_reqs.push_back(r);   // all due, re-arm saturates
        r = mk_tick('0); pending_reqs.push_back(r);     // nothing due
        r = mk_cancel(1, adds); r.cslot = 4'hF; r.cseq = '1; pending_reqs.push_back(r);
        r = mk_cancel(0, adds); r.cslot = 0; r.cseq = 0; pending_reqs.push_back(r);
        r = mk_tick(0); r.req = ott_pkg::REQ_NOP; r.now = TMAX; r.exp = TMAX; r.iv = TMAX;
        r.cslot = '1; r.cseq = '1; pending_reqs.push_back(r);
        r = mk_add(0); r.exp = 3; pending_reqs.push_back(r);
        adds = adds + 1;
        // random mix of adds, cancels, ticks and no-ops
        for (int n = 0; n < 100; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    pending_reqs.push_back(mk_add(now));
                    adds = adds + 1;
                end
                4, 5: pending_reqs.push_back(mk_cancel($urandom_range(0, 3) != 0, adds));
                6: begin
                    r = mk_tick(0); r.req = ott_pkg::REQ_NOP; pending_reqs.push_back(r);
                end
                default: begin
                    now = now + TB'($urandom_range(0, 150));
                    pending_reqs.push_back(mk_tick(now));
                end
            endcase
        end
        stim_done = 1;
    end

    // driver
    int gap_in = 0;
    always @(posedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) predict_timer_step(pending_reqs.pop_front());
            if (gap_in > 0) begin
                gap_in <= gap_in - 1;
                i_in_valid <= 0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs[0];
                i_in_valid <= 1;
                i_req_type <= r.req;
                i_now_time <= r.now;
                i_expire_time <= r.exp;
                i_repeat_interval <= r.iv;
                i_cancel_slot <= r.cslot;
                i_cancel_seq <= r.cseq;
                gap_in <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            end else begin
                i_in_valid <= 0;
            end
        end
    end

    initial begin
        i_in_valid = 0;
        i_req_type = '0;
        i_now_time = '0;
        i_expire_time = '0;
        i_repeat_interval = '0;
        i_cancel_slot = '0;
        i_cancel_seq = '0;
        i_out_stall = 0;
    end

    // monitor: compare each accepted result with the oldest expectation
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_resp e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_resps.size() == 0) begin
                $display("%0t: unexpected result kind %0d slot %0d", $time,
                         o_resp_kind, o_slot_out);
                errors++;
            end else begin
                e = expected_resps.pop_front();
                if ({o_resp_kind, o_status, o_slot_out, o_seq_out, o_earliest_changed,
                     o_next_valid, o_next_deadline, o_last} !==
                    {e.kind, e.status, e.slot, e.seq, e.early, e.nvalid, e.ndead, e.last}) begin
                    $display("%0t: mismatch expected k%0d s%0d sl%0d q%0h e%0d nv%0d nd%0h l%0d",
                             $time, e.kind, e.status, e.slot, e.seq, e.early, e.nvalid,
                             e.ndead, e.last);
                    $display("%0t:          actual k%0d s%0d sl%0d q%0h e%0d nv%0d nd%0h l%0d",
                             $time, o_resp_kind, o_status, o_slot_out, o_seq_out,
                             o_earliest_changed, o_next_valid, o_next_deadline, o_last);
                    errors++;
                end
            end
        end
        // receiver stall per result, sometimes none at all
        if (!i_rst_n) begin
            i_out_stall <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1;
        end else if (o_out_valid && !i_out_stall) begin
            stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
            i_out_stall <= 0;
        end else begin
            i_out_stall <= 0;
        end
    end

    // end of run and watchdog
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_resps.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && expected_resps.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[ordered_timer_table_unit.f]
src/ott_pkg.sv
src/ott_ram.sv
src/ott_eval.sv
src/ordered_timer_table_unit.sv
test/tb_top.sv
